/* hw/rtl/dcf_pkg.sv */
`default_nettype none
package dcf_pkg;

  // default fraction width of the fixed point format
  localparam int FracBitsDef = 16;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DAMP_BB = 3'd0,
    REG_REST_BB = 3'd1,
    REG_DAMP_BS = 3'd2,
    REG_REST_BS = 3'd3,
    REG_DAMP_SS = 3'd4,
    REG_REST_SS = 3'd5
  } reg_idx_e;

  // size class codes (bit1 first disc big, bit0 second disc big)
  localparam logic [1:0] CLS_SMALL_SMALL = 2'b00;
  localparam logic [1:0] CLS_BIG_BIG     = 2'b11;

  typedef struct packed {
    logic [31:0] damp_bb;
    logic [31:0] rest_bb;
    logic [31:0] damp_bs;
    logic [31:0] rest_bs;
    logic [31:0] damp_ss;
    logic [31:0] rest_ss;
  } coef_t;

  // per-item data that rides alongside the square root and divide pipes
  typedef struct packed {
    logic        ok;      // overlap, distinct particles, nonzero distance
    logic        rx_neg;
    logic        ry_neg;
    logic [1:0]  cls;
    logic [31:0] rc;      // summed radii
    logic [31:0] arx;
    logic [31:0] ary;
    logic [32:0] vx;      // relative velocity, two's complement
    logic [32:0] vy;
  } side_t;

endpackage
`default_nettype wire

/* hw/rtl/dcf_front.sv */
`default_nettype none
module dcf_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                vld_i,
  input  wire logic signed [31:0]  first_x_i,
  input  wire logic signed [31:0]  first_y_i,
  input  wire logic signed [31:0]  second_x_i,
  input  wire logic signed [31:0]  second_y_i,
  input  wire logic [30:0]         first_radius_i,
  input  wire logic [30:0]         second_radius_i,
  input  wire logic signed [31:0]  first_vx_i,
  input  wire logic signed [31:0]  first_vy_i,
  input  wire logic signed [31:0]  second_vx_i,
  input  wire logic signed [31:0]  second_vy_i,
  input  wire logic [1:0]          pair_class_i,
  input  wire logic                same_particle_i,
  output logic                     vld_o,
  output logic [63:0]              dd_o,
  output dcf_pkg::side_t           side_o
);

  // stage A: differences and summed radii
  logic        va_q;
  logic [32:0] rx_q, ry_q, vx_q, vy_q;
  logic [31:0] rc_q;
  logic [1:0]  cls_a_q;
  logic        same_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q     <= {second_x_i[31], second_x_i} - {first_x_i[31], first_x_i};
    ry_q     <= {second_y_i[31], second_y_i} - {first_y_i[31], first_y_i};
    vx_q     <= {first_vx_i[31], first_vx_i} - {second_vx_i[31], second_vx_i};
    vy_q     <= {first_vy_i[31], first_vy_i} - {second_vy_i[31], second_vy_i};
    rc_q     <= {1'b0, first_radius_i} + {1'b0, second_radius_i};
    cls_a_q  <= pair_class_i;
    same_a_q <= same_particle_i;
  end

  // stage B: magnitudes and squares
  logic [32:0] nrx, nry;
  logic [31:0] arx_d, ary_d;

  assign nrx   = 33'd0 - rx_q;
  assign nry   = 33'd0 - ry_q;
  assign arx_d = rx_q[32] ? nrx[31:0] : rx_q[31:0];
  assign ary_d = ry_q[32] ? nry[31:0] : ry_q[31:0];

  logic           vb_q;
  logic [63:0]    sqx_q, sqy_q, rcsq_q;
  dcf_pkg::side_t side_b_q;
  logic           same_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqx_q           <= 64'(arx_d) * 64'(arx_d);
    sqy_q           <= 64'(ary_d) * 64'(ary_d);
    rcsq_q          <= 64'(rc_q) * 64'(rc_q);
    side_b_q.ok     <= 1'b0;
    side_b_q.rx_neg <= rx_q[32];
    side_b_q.ry_neg <= ry_q[32];
    side_b_q.cls    <= cls_a_q;
    side_b_q.rc     <= rc_q;
    side_b_q.arx    <= arx_d;
    side_b_q.ary    <= ary_d;
    side_b_q.vx     <= vx_q;
    side_b_q.vy     <= vy_q;
    same_b_q        <= same_a_q;
  end

  // stage C: exact squared distance and contact test
  logic [64:0] dd_d;
  logic        ok_d;

  assign dd_d = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign ok_d = !same_b_q && (dd_d < {1'b0, rcsq_q}) && (dd_d != 65'd0);

  logic           vc_q;
  logic [63:0]    dd_q;
  dcf_pkg::side_t side_c_d;
  dcf_pkg::side_t side_c_q;

  // carry the side data on with the contact flag filled in
  always_comb begin
    side_c_d    = side_b_q;
    side_c_d.ok = ok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dd_q     <= dd_d[63:0];
    side_c_q <= side_c_d;
  end

  assign vld_o  = vc_q;
  assign dd_o   = dd_q;
  assign side_o = side_c_q;

endmodule
`default_nettype wire

/* hw/rtl/dcf_sqrt.sv */
`default_nettype none
module dcf_sqrt (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           vld_i,
  input  wire logic [63:0]    rad_i,
  input  wire dcf_pkg::side_t side_i,
  output logic                vld_o,
  output logic [31:0]         root_o,
  output dcf_pkg::side_t      side_o
);

  // one root bit per stage, most significant first
  localparam int Steps = 32;

  logic [Steps:0]  vld_w;
  logic [32:0]     rem_w  [Steps+1];
  logic [31:0]     root_w [Steps+1];
  logic [63:0]     rad_w  [Steps+1];
  dcf_pkg::side_t  side_w [Steps+1];

  assign vld_w[0]  = vld_i;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = rad_i;
  assign side_w[0] = side_i;

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [34:0]    cur, trial, diff;
    logic           ge;
    logic           vld_q;
    logic [32:0]    rem_q;
    logic [31:0]    root_q;
    logic [63:0]    rad_q;
    dcf_pkg::side_t side_q;

    // bring down two radicand bits and try the next root bit
    assign cur   = {rem_w[i], rad_w[i][63:62]};
    assign trial = {1'b0, root_w[i], 2'b01};
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q  <= ge ? diff[32:0] : cur[32:0];
      root_q <= {root_w[i][30:0], ge};
      rad_q  <= {rad_w[i][61:0], 2'b00};
      side_q <= side_w[i];
    end

    assign vld_w[i+1]  = vld_q;
    assign rem_w[i+1]  = rem_q;
    assign root_w[i+1] = root_q;
    assign rad_w[i+1]  = rad_q;
    assign side_w[i+1] = side_q;
  end

  assign vld_o  = vld_w[Steps];
  assign root_o = root_w[Steps];
  assign side_o = side_w[Steps];

endmodule
`default_nettype wire

/* hw/rtl/dcf_div.sv */
`default_nettype none
module dcf_div #(
  parameter int FRACTION_BITS = dcf_pkg::FracBitsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             vld_i,
  input  wire logic [31:0]      dist_i,
  input  wire dcf_pkg::side_t   side_i,
  output logic                  vld_o,
  output logic [FRACTION_BITS:0] nxm_o,
  output logic [FRACTION_BITS:0] nym_o,
  output logic [31:0]           dist_o,
  output dcf_pkg::side_t        side_o
);

  // |r| <= dist, so the quotient fits FRACTION_BITS+1 bits: one bit per stage
  localparam int Steps = FRACTION_BITS + 1;
  localparam int QW    = FRACTION_BITS + 1;

  logic [Steps:0]  vld_w;
  logic [32:0]     remx_w [Steps+1];
  logic [32:0]     remy_w [Steps+1];
  logic [QW-1:0]   qx_w   [Steps+1];
  logic [QW-1:0]   qy_w   [Steps+1];
  logic [31:0]     dist_w [Steps+1];
  dcf_pkg::side_t  side_w [Steps+1];

  assign vld_w[0]  = vld_i;
  assign remx_w[0] = {1'b0, side_i.arx};
  assign remy_w[0] = {1'b0, side_i.ary};
  assign qx_w[0]   = '0;
  assign qy_w[0]   = '0;
  assign dist_w[0] = dist_i;
  assign side_w[0] = side_i;

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [32:0]    dx, dy, selx, sely;
    logic           gex, gey;
    logic           vld_q;
    logic [32:0]    remx_q, remy_q;
    logic [QW-1:0]  qx_q, qy_q;
    logic [31:0]    dist_q;
    dcf_pkg::side_t side_q;

    // subtract the divisor where it fits, then shift in a zero
    assign gex  = remx_w[i] >= {1'b0, dist_w[i]};
    assign gey  = remy_w[i] >= {1'b0, dist_w[i]};
    assign dx   = remx_w[i] - {1'b0, dist_w[i]};
    assign dy   = remy_w[i] - {1'b0, dist_w[i]};
    assign selx = gex ? dx : remx_w[i];
    assign sely = gey ? dy : remy_w[i];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      remx_q <= {selx[31:0], 1'b0};
      remy_q <= {sely[31:0], 1'b0};
      qx_q   <= {qx_w[i][QW-2:0], gex};
      qy_q   <= {qy_w[i][QW-2:0], gey};
      dist_q <= dist_w[i];
      side_q <= side_w[i];
    end

    assign vld_w[i+1]  = vld_q;
    assign remx_w[i+1] = remx_q;
    assign remy_w[i+1] = remy_q;
    assign qx_w[i+1]   = qx_q;
    assign qy_w[i+1]   = qy_q;
    assign dist_w[i+1] = dist_q;
    assign side_w[i+1] = side_q;
  end

  assign vld_o  = vld_w[Steps];
  assign nxm_o  = qx_w[Steps];
  assign nym_o  = qy_w[Steps];
  assign dist_o = dist_w[Steps];
  assign side_o = side_w[Steps];

endmodule
`default_nettype wire

/* hw/rtl/dcf_force.sv */
`default_nettype none
module dcf_force #(
  parameter int FRACTION_BITS = dcf_pkg::FracBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              vld_i,
  input  wire logic [FRACTION_BITS:0] nxm_i,
  input  wire logic [FRACTION_BITS:0] nym_i,
  input  wire logic [31:0]       dist_i,
  input  wire dcf_pkg::side_t    side_i,
  input  wire dcf_pkg::coef_t    coef_i,
  output logic                   vld_o,
  output logic signed [31:0]     force_x_o,
  output logic signed [31:0]     force_y_o,
  output logic                   applied_o
);

  localparam int F    = FRACTION_BITS;
  localparam int NW   = F + 1;       // normal magnitude
  localparam int PW   = F + 35;      // velocity times signed normal
  localparam int SW   = F + 36;      // dot product
  localparam int MagW = 62 - F;      // magnitude, capped at all ones
  localparam int FxW  = 63 - F;      // force magnitude after rescale

  // saturate a force magnitude into 32-bit two's complement
  function automatic logic [31:0] sat_out(input logic [FxW-1:0] m, input logic neg);
    logic        big;
    logic [31:0] r;
    if (neg) begin
      big = (|m[FxW-1:32]) || (m[31] && (|m[30:0]));
      r   = big ? 32'h8000_0000 : 32'd0 - m[31:0];
    end else begin
      big = |m[FxW-1:31];
      r   = big ? 32'h7FFF_FFFF : {1'b0, m[30:0]};
    end
    return r;
  endfunction

  // E1: signed normal times relative velocity, overlap
  logic signed [F+1:0] nxs, nys;
  assign nxs = side_i.rx_neg ? -$signed({1'b0, nxm_i}) : $signed({1'b0, nxm_i});
  assign nys = side_i.ry_neg ? -$signed({1'b0, nym_i}) : $signed({1'b0, nym_i});

  logic                 v1_q;
  logic signed [PW-1:0] px_q, py_q;
  logic [31:0]          ov1_q;
  logic [NW-1:0]        nxm1_q, nym1_q;
  logic [1:0]           cls1_q;
  logic                 ok1_q, rxn1_q, ryn1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= $signed(side_i.vx) * nxs;
    py_q   <= $signed(side_i.vy) * nys;
    ov1_q  <= side_i.rc - dist_i;
    nxm1_q <= nxm_i;
    nym1_q <= nym_i;
    cls1_q <= side_i.cls;
    ok1_q  <= side_i.ok;
    rxn1_q <= side_i.rx_neg;
    ryn1_q <= side_i.ry_neg;
  end

  // E2: dot product, truncated magnitude, coefficient select
  logic [SW-1:0] s_d, sabs_d;
  logic [31:0]   dmp_d, rst_d;

  assign s_d    = {px_q[PW-1], px_q} + {py_q[PW-1], py_q};
  assign sabs_d = s_d[SW-1] ? ({SW{1'b0}} - s_d) : s_d;

  always_comb begin
    unique case (cls1_q)
      dcf_pkg::CLS_BIG_BIG: begin
        dmp_d = coef_i.damp_bb;
        rst_d = coef_i.rest_bb;
      end
      dcf_pkg::CLS_SMALL_SMALL: begin
        dmp_d = coef_i.damp_ss;
        rst_d = coef_i.rest_ss;
      end
      default: begin
        dmp_d = coef_i.damp_bs;
        rst_d = coef_i.rest_bs;
      end
    endcase
  end

  logic          v2_q;
  logic [33:0]   ad2_q;
  logic          sneg2_q;
  logic [31:0]   dmp2_q, rst2_q, ov2_q;
  logic [NW-1:0] nxm2_q, nym2_q;
  logic          ok2_q, rxn2_q, ryn2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ad2_q   <= sabs_d[F+33:F];
    sneg2_q <= s_d[SW-1];
    dmp2_q  <= dmp_d;
    rst2_q  <= rst_d;
    ov2_q   <= ov1_q;
    nxm2_q  <= nxm1_q;
    nym2_q  <= nym1_q;
    ok2_q   <= ok1_q;
    rxn2_q  <= rxn1_q;
    ryn2_q  <= ryn1_q;
  end

  // E3: damping and spring products
  logic          v3_q;
  logic [65:0]   pa3_q;
  logic [63:0]   pb3_q;
  logic          sneg3_q;
  logic [NW-1:0] nxm3_q, nym3_q;
  logic          ok3_q, rxn3_q, ryn3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pa3_q   <= 66'(dmp2_q) * 66'(ad2_q);
    pb3_q   <= 64'(rst2_q) * 64'(ov2_q);
    sneg3_q <= sneg2_q;
    nxm3_q  <= nxm2_q;
    nym3_q  <= nym2_q;
    ok3_q   <= ok2_q;
    rxn3_q  <= rxn2_q;
    ryn3_q  <= ryn2_q;
  end

  // E4: combine, rescale and cap the magnitude
  logic [66:0]     sum_d, dif_d, tot_d;
  logic            push_d;
  logic [MagW-1:0] mag_d;

  assign sum_d  = 67'(pa3_q) + 67'(pb3_q);
  assign dif_d  = 67'(pb3_q) - 67'(pa3_q);
  assign push_d = !sneg3_q || (pa3_q < 66'(pb3_q));
  assign tot_d  = sneg3_q ? dif_d : sum_d;
  assign mag_d  = (|tot_d[66:62]) ? {MagW{1'b1}} : tot_d[61:F];

  logic            v4_q;
  logic [MagW-1:0] mag4_q;
  logic [NW-1:0]   nxm4_q, nym4_q;
  logic            ok4_q, rxn4_q, ryn4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag4_q <= mag_d;
    nxm4_q <= nxm3_q;
    nym4_q <= nym3_q;
    ok4_q  <= ok3_q && push_d && (mag_d != '0);
    rxn4_q <= rxn3_q;
    ryn4_q <= ryn3_q;
  end

  // E5: force components
  logic [62:0] fx_d, fy_d;
  assign fx_d = 63'(mag4_q) * 63'(nxm4_q);
  assign fy_d = 63'(mag4_q) * 63'(nym4_q);

  logic           v5_q;
  logic [FxW-1:0] fxm5_q, fym5_q;
  logic           ok5_q, rxn5_q, ryn5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fxm5_q <= fx_d[62:F];
    fym5_q <= fy_d[62:F];
    ok5_q  <= ok4_q;
    rxn5_q <= rxn4_q;
    ryn5_q <= ryn4_q;
  end

  // output register: saturate, drop the item to zero where no push
  logic        applied_d;
  logic        vo_q, applied_q;
  logic [31:0] fx_q, fy_q;

  assign applied_d = ok5_q && ((|fxm5_q) || (|fym5_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fx_q      <= ok5_q ? sat_out(fxm5_q, !rxn5_q) : 32'd0;
    fy_q      <= ok5_q ? sat_out(fym5_q, !ryn5_q) : 32'd0;
    applied_q <= applied_d;
  end

  assign vld_o     = vo_q;
  assign force_x_o = fx_q;
  assign force_y_o = fy_q;
  assign applied_o = applied_q;

endmodule
`default_nettype wire

/* hw/rtl/disc_contact_force.sv */
// channel   | handshake              | payload
// ----------+------------------------+-----------------------------------------
// pair in   | start & !busy          | positions, radii, velocities, class, flag
// force out | result_valid_o strobe  | force_x_o, force_y_o, applied_o
// config    | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One pair enters every cycle; busy stays low.
// The pipeline has 3 front stages, 32 square root stages (one root bit each),
// FRACTION_BITS + 1 divide stages (one quotient bit each) and 6 force stages
// with the output register.
// Reset clears all valid bits at once; the coefficient registers reset to zero.
// Results are strobed for one cycle and cannot be held off.
`default_nettype none
module disc_contact_force #(
  parameter int FRACTION_BITS = dcf_pkg::FracBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [31:0]            first_x_i,
  input  wire logic signed [31:0]            first_y_i,
  input  wire logic signed [31:0]            second_x_i,
  input  wire logic signed [31:0]            second_y_i,
  input  wire logic [30:0]                   first_radius_i,
  input  wire logic [30:0]                   second_radius_i,
  input  wire logic signed [31:0]            first_vx_i,
  input  wire logic signed [31:0]            first_vy_i,
  input  wire logic signed [31:0]            second_vx_i,
  input  wire logic signed [31:0]            second_vy_i,
  input  wire logic [1:0]                    pair_class_i,
  input  wire logic                          same_particle_i,
  output logic                               result_valid_o,
  output logic signed [31:0]                 force_x_o,
  output logic signed [31:0]                 force_y_o,
  output logic                               applied_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [dcf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [dcf_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  // the pipeline never stalls
  assign busy = 1'b0;

  // coefficient registers
  dcf_pkg::coef_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      unique case (dcf_pkg::reg_idx_e'(cfg_idx_i))
        dcf_pkg::REG_DAMP_BB: coef_q.damp_bb <= cfg_wdata_i;
        dcf_pkg::REG_REST_BB: coef_q.rest_bb <= cfg_wdata_i;
        dcf_pkg::REG_DAMP_BS: coef_q.damp_bs <= cfg_wdata_i;
        dcf_pkg::REG_REST_BS: coef_q.rest_bs <= cfg_wdata_i;
        dcf_pkg::REG_DAMP_SS: coef_q.damp_ss <= cfg_wdata_i;
        dcf_pkg::REG_REST_SS: coef_q.rest_ss <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic           fr_vld;
  logic [63:0]    fr_dd;
  dcf_pkg::side_t fr_side;

  dcf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vld_i           (start && !busy),
    .first_x_i       (first_x_i),
    .first_y_i       (first_y_i),
    .second_x_i      (second_x_i),
    .second_y_i      (second_y_i),
    .first_radius_i  (first_radius_i),
    .second_radius_i (second_radius_i),
    .first_vx_i      (first_vx_i),
    .first_vy_i      (first_vy_i),
    .second_vx_i     (second_vx_i),
    .second_vy_i     (second_vy_i),
    .pair_class_i    (pair_class_i),
    .same_particle_i (same_particle_i),
    .vld_o           (fr_vld),
    .dd_o            (fr_dd),
    .side_o          (fr_side)
  );

  logic           sq_vld;
  logic [31:0]    sq_root;
  dcf_pkg::side_t sq_side;

  dcf_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (fr_vld),
    .rad_i  (fr_dd),
    .side_i (fr_side),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  logic                   dv_vld;
  logic [FRACTION_BITS:0] dv_nxm, dv_nym;
  logic [31:0]            dv_dist;
  dcf_pkg::side_t         dv_side;

  dcf_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (sq_vld),
    .dist_i (sq_root),
    .side_i (sq_side),
    .vld_o  (dv_vld),
    .nxm_o  (dv_nxm),
    .nym_o  (dv_nym),
    .dist_o (dv_dist),
    .side_o (dv_side)
  );

  dcf_force #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_force (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (dv_vld),
    .nxm_i     (dv_nxm),
    .nym_i     (dv_nym),
    .dist_i    (dv_dist),
    .side_i    (dv_side),
    .coef_i    (coef_q),
    .vld_o     (result_valid_o),
    .force_x_o (force_x_o),
    .force_y_o (force_y_o),
    .applied_o (applied_o)
  );

endmodule
`default_nettype wire

/* hw/rtl/dcf_checker.sv */
`default_nettype none
module dcf_checker #(
  parameter int FRACTION_BITS = dcf_pkg::FracBitsDef
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         same_particle_i,
  input wire logic                         result_valid_o,
  input wire logic signed [31:0]           force_x_o,
  input wire logic signed [31:0]           force_y_o,
  input wire logic                         applied_o
);

  localparam int Lat  = FRACTION_BITS + 42;
  localparam int LatW = $clog2(Lat + 1);

  // count cycles since reset so that latency checks skip the fill
  logic [LatW-1:0] warm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (warm_q != LatW'(Lat)) begin
      warm_q <= warm_q + LatW'(1);
    end
  end

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm_q == LatW'(Lat)) |-> (result_valid_o == $past(start && !busy, Lat)))
    else $error("result strobe does not follow an accepted item");

  a_same_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((warm_q == LatW'(Lat)) && $past(start && !busy && same_particle_i, Lat))
      |-> (result_valid_o && !applied_o))
    else $error("same particle pair produced a force");

  a_applied_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && applied_o) |-> ((force_x_o != 32'sd0) || (force_y_o != 32'sd0)))
    else $error("applied with zero force");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !applied_o) |-> ((force_x_o == 32'sd0) && (force_y_o == 32'sd0)))
    else $error("nonzero force without applied");

endmodule

bind disc_contact_force dcf_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_dcf_checker (.*);
`default_nettype wire
